// File: rtl/wkfc_pkg.sv
// shared constants, codes and item types of the knee/fold/clamp waveshaper
`default_nettype none

package wkfc_pkg;

    // Q1.15 magnitudes run up to and including +1.0, so they take 16 bits
    localparam int MAG_W = 16;
    localparam logic [MAG_W-1:0] Q_ONE = 16'd32768;
    localparam logic [MAG_W-1:0] Q_MAX_POS = 16'd32767;

    localparam logic signed [14:0] HALF_SPAN_S = 15'sd5000;
    localparam logic signed [14:0] FULL_SPAN_S = 15'sd10000;
    localparam int HALF_SPAN_MV = 5000;
    localparam int HALF_SPAN_RND = HALF_SPAN_MV / 2;

    localparam int KNEE_LO = 4915;
    localparam int KNEE_HI = 32768 - KNEE_LO;
    localparam int KNEE_LO_RND = KNEE_LO / 2;
    localparam int KNEE_HI_RND = KNEE_HI / 2;
    localparam int FOLD_GAIN = 5;

    // exact floor division for numerators below 2^28 and divisors below 2^15
    localparam int RECIP_SHIFT = 43;
    localparam int RECIP_W = 31;
    localparam logic [RECIP_W-1:0] RECIP_SPAN =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + HALF_SPAN_MV - 1) / HALF_SPAN_MV);
    localparam logic [RECIP_W-1:0] RECIP_LO =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + KNEE_LO - 1) / KNEE_LO);
    localparam logic [RECIP_W-1:0] RECIP_HI =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + KNEE_HI - 1) / KNEE_HI);

    // configuration register indexes and codes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHAPER_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MODE = 1'b1;

    localparam logic SHAPE_KNEE = 1'b0;
    localparam logic SHAPE_CLAMP_FOLD = 1'b1;
    localparam logic RANGE_BIPOLAR = 1'b0;
    localparam logic RANGE_UNIPOLAR = 1'b1;

    // normalized sample and modulation, handed from the front end to the shaper
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] m;
        logic             pos_mod;
    } norm_item_t;

    // shaped magnitude with sign, handed to the output mapper
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } shape_item_t;

endpackage

`default_nettype wire

// File: rtl/wkfc_norm.sv
// front end: range clamp, millivolt to Q1.15 normalizing by reciprocal multiply
`default_nettype none

module wkfc_norm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                range_mode,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [14:0]  sample_mv,
    input  wire logic signed [15:0]  mod_amount,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output wkfc_pkg::norm_item_t     out_item
);

    localparam int NUM_W = 28;
    localparam int PROD_W = NUM_W + wkfc_pkg::RECIP_W;

    logic signed [14:0] v_cl;
    logic signed [14:0] v_ctr;
    logic [12:0] v_abs;
    logic [wkfc_pkg::MAG_W-1:0] m_abs;
    logic [NUM_W-1:0] num_a;

    logic a_valid_reg;
    logic a_ready;
    logic [NUM_W-1:0] a_num_reg;
    logic a_neg_reg;
    logic [wkfc_pkg::MAG_W-1:0] a_m_reg;
    logic a_pos_reg;

    logic b_valid_reg;
    logic b_ready;
    logic [PROD_W-1:0] prod_b;
    logic [wkfc_pkg::MAG_W-1:0] x_next;
    logic [wkfc_pkg::MAG_W-1:0] b_x_reg;
    logic b_neg_reg;
    logic [wkfc_pkg::MAG_W-1:0] b_m_reg;
    logic b_pos_reg;

    always_comb
    begin
        if (range_mode == wkfc_pkg::RANGE_UNIPOLAR)
        begin
            if (sample_mv < 15'sd0)
                v_cl = 15'sd0;
            else if (sample_mv > wkfc_pkg::FULL_SPAN_S)
                v_cl = wkfc_pkg::FULL_SPAN_S;
            else
                v_cl = sample_mv;
            v_ctr = v_cl - wkfc_pkg::HALF_SPAN_S;
        end
        else
        begin
            if (sample_mv < -wkfc_pkg::HALF_SPAN_S)
                v_cl = -wkfc_pkg::HALF_SPAN_S;
            else if (sample_mv > wkfc_pkg::HALF_SPAN_S)
                v_cl = wkfc_pkg::HALF_SPAN_S;
            else
                v_cl = sample_mv;
            v_ctr = v_cl;
        end
        v_abs = v_ctr[14] ? 13'(-v_ctr) : 13'(v_ctr);
        // most negative modulation wraps to 0x8000, which reads as exactly 1.0
        m_abs = mod_amount[15] ? 16'(-mod_amount) : 16'(mod_amount);
        num_a = {v_abs, 15'b0} + NUM_W'(wkfc_pkg::HALF_SPAN_RND);
    end

    assign a_ready = !a_valid_reg || b_ready;
    assign b_ready = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_num_reg <= num_a;
            a_neg_reg <= v_ctr[14];
            a_m_reg <= m_abs;
            a_pos_reg <= !mod_amount[15];
        end
        if (b_ready && a_valid_reg)
        begin
            b_x_reg <= x_next;
            b_neg_reg <= a_neg_reg;
            b_m_reg <= a_m_reg;
            b_pos_reg <= a_pos_reg;
        end
    end

    // floor divide by the half span
    assign prod_b = PROD_W'(a_num_reg) * PROD_W'(wkfc_pkg::RECIP_SPAN);
    assign x_next = prod_b[wkfc_pkg::RECIP_SHIFT +: wkfc_pkg::MAG_W];

    assign out_valid = b_valid_reg;
    assign out_item.neg = b_neg_reg;
    assign out_item.x = b_x_reg;
    assign out_item.m = b_m_reg;
    assign out_item.pos_mod = b_pos_reg;

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> b_x_reg <= wkfc_pkg::Q_ONE)
        else $error("normalized magnitude above one");

endmodule

`default_nettype wire

// File: rtl/wkfc_shape.sv
// shaper core: knee crossfade and clamp/fold over three register stages
`default_nettype none

module wkfc_shape (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shaper_mode,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire wkfc_pkg::norm_item_t in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output wkfc_pkg::shape_item_t    out_item
);

    localparam int MW = wkfc_pkg::MAG_W;
    localparam int OPB_W = 18;
    localparam int PROD_W = 33;
    localparam int KNUM_W = 28;
    localparam int KPROD_W = KNUM_W + wkfc_pkg::RECIP_W;
    localparam int TOT_W = 35;

    // stage c: operand selection and the shared multiplier
    logic [MW-1:0] op_a;
    logic [OPB_W-1:0] op_b;
    logic [13:0] half_c;
    logic [MW-1:0] base_c;
    logic div_lo_c;
    logic [PROD_W-1:0] prod_c;

    logic c_valid_reg;
    logic c_ready;
    logic [PROD_W-1:0] c_prod_reg;
    logic [MW-1:0] c_base_reg;
    logic c_div_lo_reg;
    logic [MW-1:0] c_x_reg;
    logic [MW-1:0] c_m_reg;
    logic c_neg_reg;
    logic c_pos_reg;
    logic c_bypass_reg;

    // stage d: knee curve value and clamp/fold magnitude
    logic [wkfc_pkg::RECIP_W-1:0] recip_d;
    logic [KPROD_W-1:0] kprod_d;
    logic [MW-1:0] e_next;
    logic [OPB_W-1:0] s_d;
    logic [MW-1:0] cf_next;

    logic d_valid_reg;
    logic d_ready;
    logic [MW-1:0] d_e_reg;
    logic [MW-1:0] d_cf_reg;
    logic [MW-1:0] d_x_reg;
    logic [MW-1:0] d_m_reg;
    logic d_neg_reg;
    logic d_bypass_reg;

    // stage e: crossfade and result selection
    logic signed [MW:0] diff_e;
    logic signed [2*MW+1:0] xfade_e;
    logic signed [TOT_W-1:0] total_e;
    logic [MW-1:0] knee_mag;
    logic [MW-1:0] mag_next;

    logic e_valid_reg;
    logic e_ready;
    logic [MW-1:0] e_mag_reg;
    logic e_neg_reg;

    always_comb
    begin
        op_a = in_item.x;
        op_b = OPB_W'(in_item.x);
        half_c = '0;
        base_c = '0;
        div_lo_c = 1'b0;
        if (shaper_mode == wkfc_pkg::SHAPE_CLAMP_FOLD)
        begin
            op_b = OPB_W'(wkfc_pkg::Q_ONE) + OPB_W'(in_item.m) * OPB_W'(wkfc_pkg::FOLD_GAIN);
        end
        else if (in_item.pos_mod)
        begin
            // boost curve: steep below the knee, shallow above
            if (in_item.x <= MW'(wkfc_pkg::KNEE_LO))
            begin
                op_b = OPB_W'(wkfc_pkg::KNEE_HI);
                half_c = 14'(wkfc_pkg::KNEE_LO_RND);
                div_lo_c = 1'b1;
            end
            else
            begin
                op_a = in_item.x - MW'(wkfc_pkg::KNEE_LO);
                op_b = OPB_W'(wkfc_pkg::KNEE_LO);
                half_c = 14'(wkfc_pkg::KNEE_HI_RND);
                base_c = MW'(wkfc_pkg::KNEE_HI);
            end
        end
        else
        begin
            // cut curve: shallow up to the high knee, steep above
            if (in_item.x <= MW'(wkfc_pkg::KNEE_HI))
            begin
                op_b = OPB_W'(wkfc_pkg::KNEE_LO);
                half_c = 14'(wkfc_pkg::KNEE_HI_RND);
            end
            else
            begin
                op_a = in_item.x - MW'(wkfc_pkg::KNEE_HI);
                op_b = OPB_W'(wkfc_pkg::KNEE_HI);
                half_c = 14'(wkfc_pkg::KNEE_LO_RND);
                base_c = MW'(wkfc_pkg::KNEE_LO);
                div_lo_c = 1'b1;
            end
        end
        prod_c = PROD_W'(op_a) * PROD_W'(op_b) + PROD_W'(half_c);
    end

    always_comb
    begin
        recip_d = c_div_lo_reg ? wkfc_pkg::RECIP_LO : wkfc_pkg::RECIP_HI;
        kprod_d = KPROD_W'(c_prod_reg[KNUM_W-1:0]) * KPROD_W'(recip_d);
        e_next = c_base_reg + kprod_d[wkfc_pkg::RECIP_SHIFT +: MW];
        s_d = c_prod_reg[PROD_W-1:15];
        if (!c_pos_reg)
            cf_next = (s_d > OPB_W'(wkfc_pkg::Q_ONE)) ? wkfc_pkg::Q_ONE : s_d[MW-1:0];
        else if (s_d[15])
            // odd integer part folds back down
            cf_next = wkfc_pkg::Q_ONE - MW'(s_d[14:0]);
        else
            cf_next = MW'(s_d[14:0]);
    end

    always_comb
    begin
        diff_e = $signed({1'b0, d_e_reg}) - $signed({1'b0, d_x_reg});
        xfade_e = diff_e * $signed({1'b0, d_m_reg});
        total_e = $signed(TOT_W'({d_x_reg, 15'b0})) + TOT_W'(xfade_e)
                  + TOT_W'(wkfc_pkg::Q_ONE >> 1);
        knee_mag = total_e[15 +: MW];
        if (d_bypass_reg)
            mag_next = d_x_reg;
        else if (shaper_mode == wkfc_pkg::SHAPE_CLAMP_FOLD)
            mag_next = d_cf_reg;
        else
            mag_next = knee_mag;
    end

    assign c_ready = !c_valid_reg || d_ready;
    assign d_ready = !d_valid_reg || e_ready;
    assign e_ready = !e_valid_reg || out_ready;
    assign in_ready = c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
                c_valid_reg <= in_valid;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
            if (e_ready)
                e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_prod_reg <= prod_c;
            c_base_reg <= base_c;
            c_div_lo_reg <= div_lo_c;
            c_x_reg <= in_item.x;
            c_m_reg <= in_item.m;
            c_neg_reg <= in_item.neg;
            c_pos_reg <= in_item.pos_mod;
            c_bypass_reg <= (in_item.x == '0) || (in_item.m == '0);
        end
        if (d_ready && c_valid_reg)
        begin
            d_e_reg <= e_next;
            d_cf_reg <= cf_next;
            d_x_reg <= c_x_reg;
            d_m_reg <= c_m_reg;
            d_neg_reg <= c_neg_reg;
            d_bypass_reg <= c_bypass_reg;
        end
        if (e_ready && d_valid_reg)
        begin
            e_mag_reg <= mag_next;
            e_neg_reg <= d_neg_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_item.neg = e_neg_reg;
    assign out_item.mag = e_mag_reg;

    a_shape_range: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> e_mag_reg <= wkfc_pkg::Q_ONE)
        else $error("shaped magnitude above one");

endmodule

`default_nettype wire

// File: rtl/wkfc_outmap.sv
// output stage: Q1.15 back to millivolts, saturation, output register
`default_nettype none

module wkfc_outmap (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 range_mode,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire wkfc_pkg::shape_item_t in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [14:0]        shaped_mv,
    output logic signed [15:0]        shaped_norm
);

    localparam int MVP_W = 29;

    logic [MVP_W-1:0] mvp;
    logic [12:0] mv_mag;
    logic signed [14:0] mv_next;
    logic signed [15:0] norm_next;

    logic out_valid_reg;
    logic signed [14:0] mv_reg;
    logic signed [15:0] norm_reg;

    always_comb
    begin
        mvp = MVP_W'(in_item.mag) * MVP_W'(wkfc_pkg::HALF_SPAN_MV)
              + MVP_W'(wkfc_pkg::Q_ONE >> 1);
        mv_mag = mvp[15 +: 13];
        mv_next = in_item.neg ? -$signed({2'b0, mv_mag}) : $signed({2'b0, mv_mag});
        if (range_mode == wkfc_pkg::RANGE_UNIPOLAR)
            mv_next = mv_next + wkfc_pkg::HALF_SPAN_S;
        // +1.0 saturates, -1.0 fits as is
        if (in_item.neg)
            norm_next = $signed(16'(17'd0 - 17'(in_item.mag)));
        else if (in_item.mag[15])
            norm_next = $signed(wkfc_pkg::Q_MAX_POS);
        else
            norm_next = $signed(in_item.mag);
    end

    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mv_reg <= mv_next;
            norm_reg <= norm_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign shaped_mv = mv_reg;
    assign shaped_norm = norm_reg;

    a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mv_reg >= -wkfc_pkg::HALF_SPAN_S) && (mv_reg <= wkfc_pkg::FULL_SPAN_S))
        else $error("output voltage outside both ranges");

endmodule

`default_nettype wire

// File: rtl/waveshaper_knee_fold_clamp.sv
// top level of the knee/fold/clamp waveshaper: config registers and pipeline
//
//  channel   dir   signals                                     moves
//  s_axis    in    tvalid tready tdata[31:0]                   one sample request
//  m_axis    out   tvalid tready tdata[31:0]                   one shaped result
//  cfg       in    cfg_we cfg_index cfg_wdata                  register write
//
//  six register stages: clamp/normalize, divide, multiply, knee/fold, crossfade, output
//  one request per cycle sustained while the output is not stalled
//  each stage has its own valid bit and moves when the stage after it has room
//  a stalled output holds its data; upstream stages keep filling bubbles meanwhile
//  reset clears all valid bits and sets both mode registers to zero
`default_nettype none

module waveshaper_knee_fold_clamp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [14:0] sample_mv, [30:15] mod_amount, [31] unused
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [14:0] shaped_mv, [30:15] shaped_norm, [31] zero
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [wkfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        cfg_wdata
);

    logic shaper_mode_reg;
    logic range_mode_reg;

    logic norm_valid;
    logic norm_ready;
    wkfc_pkg::norm_item_t norm_item;

    logic shape_valid;
    logic shape_ready;
    wkfc_pkg::shape_item_t shape_item;

    logic signed [14:0] shaped_mv;
    logic signed [15:0] shaped_norm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaper_mode_reg <= wkfc_pkg::SHAPE_KNEE;
            range_mode_reg <= wkfc_pkg::RANGE_BIPOLAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wkfc_pkg::CFG_SHAPER_MODE: shaper_mode_reg <= cfg_wdata;
                wkfc_pkg::CFG_RANGE_MODE:  range_mode_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wkfc_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .range_mode (range_mode_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample_mv  ($signed(s_axis_tdata[14:0])),
        .mod_amount ($signed(s_axis_tdata[30:15])),
        .out_valid  (norm_valid),
        .out_ready  (norm_ready),
        .out_item   (norm_item)
    );

    wkfc_shape u_shape (
        .clk         (clk),
        .rst_n       (rst_n),
        .shaper_mode (shaper_mode_reg),
        .in_valid    (norm_valid),
        .in_ready    (norm_ready),
        .in_item     (norm_item),
        .out_valid   (shape_valid),
        .out_ready   (shape_ready),
        .out_item    (shape_item)
    );

    wkfc_outmap u_outmap (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_mode  (range_mode_reg),
        .in_valid    (shape_valid),
        .in_ready    (shape_ready),
        .in_item     (shape_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .shaped_mv   (shaped_mv),
        .shaped_norm (shaped_norm)
    );

    assign m_axis_tdata = {1'b0, shaped_norm, shaped_mv};

    // the input only backs up when every stage is full, output included
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: test/tb.sv
// self-checking testbench for the knee/fold/clamp waveshaper stream block
`timescale 1ns / 100ps

module tb;

    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint Q1 = 32768;

    typedef struct packed {
        logic signed [14:0] mv;
        logic signed [15:0] norm;
    } shaped_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [wkfc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic        cfg_wdata = 1'b0;

    // local copy of the mode registers
    logic shaper_mode_q = wkfc_pkg::SHAPE_KNEE;
    logic range_mode_q = wkfc_pkg::RANGE_BIPOLAR;

    shaped_t shaped_q[$];
    int errors = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int cycle_count = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_max = 0;

    // receiver stall pattern and long hold-off
    int stall_pct = 0;
    int stall_len = 0;
    int hold_off_req = 0;
    int hold_cnt = 0;
    int rx_phase = 0;

    waveshaper_knee_fold_clamp u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint div_round(input longint num, input longint den);
        return (num + den / 2) / den;
    endfunction

    function automatic shaped_t predict_shape(input logic signed [14:0] smp,
                                              input logic signed [15:0] md);
        longint v, mo, x, m, e, mag, r, mv, s, ip, fr;
        logic neg;
        shaped_t res;
        v = smp;
        mo = md;
        if (range_mode_q == wkfc_pkg::RANGE_UNIPOLAR)
        begin
            if (v < 0) v = 0;
            if (v > 2 * wkfc_pkg::HALF_SPAN_MV) v = 2 * wkfc_pkg::HALF_SPAN_MV;
            v = v - wkfc_pkg::HALF_SPAN_MV;
        end
        else
        begin
            if (v < -wkfc_pkg::HALF_SPAN_MV) v = -wkfc_pkg::HALF_SPAN_MV;
            if (v > wkfc_pkg::HALF_SPAN_MV) v = wkfc_pkg::HALF_SPAN_MV;
        end
        neg = (v < 0);
        x = ((neg ? -v : v) * Q1 + wkfc_pkg::HALF_SPAN_MV / 2) / wkfc_pkg::HALF_SPAN_MV;
        m = (mo < 0) ? -mo : mo;
        if (x == 0 || m == 0)
            mag = x;
        else if (shaper_mode_q == wkfc_pkg::SHAPE_KNEE)
        begin
            // positive mod boosts, negative mod cuts
            if (mo > 0)
            begin
                if (x <= wkfc_pkg::KNEE_LO)
                    e = div_round(x * wkfc_pkg::KNEE_HI, wkfc_pkg::KNEE_LO);
                else
                    e = wkfc_pkg::KNEE_HI
                        + div_round((x - wkfc_pkg::KNEE_LO) * wkfc_pkg::KNEE_LO,
                                    wkfc_pkg::KNEE_HI);
            end
            else
            begin
                if (x <= wkfc_pkg::KNEE_HI)
                    e = div_round(x * wkfc_pkg::KNEE_LO, wkfc_pkg::KNEE_HI);
                else
                    e = wkfc_pkg::KNEE_LO
                        + div_round((x - wkfc_pkg::KNEE_HI) * wkfc_pkg::KNEE_HI,
                                    wkfc_pkg::KNEE_LO);
            end
            mag = (x * (Q1 - m) + e * m + Q1 / 2) / Q1;
        end
        else
        begin
            s = (x * (Q1 + wkfc_pkg::FOLD_GAIN * m)) / Q1;
            if (mo < 0)
                mag = (s > Q1) ? Q1 : s;
            else
            begin
                ip = s / Q1;
                fr = s % Q1;
                mag = (ip % 2 == 1) ? Q1 - fr : fr;
            end
        end
        r = neg ? -mag : mag;
        mv = (mag * wkfc_pkg::HALF_SPAN_MV + Q1 / 2) / Q1;
        if (r < 0) mv = -mv;
        if (range_mode_q == wkfc_pkg::RANGE_UNIPOLAR) mv = mv + wkfc_pkg::HALF_SPAN_MV;
        // exactly +1.0 saturates in the normalized field only
        if (r > Q1 - 1) r = Q1 - 1;
        res.mv = mv[14:0];
        res.norm = r[15:0];
        return res;
    endfunction

    task automatic send_request(input logic signed [14:0] smp,
                                input logic signed [15:0] md);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {1'b0, md, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        shaped_q.push_back(predict_shape(smp, md));
        requests_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wkfc_pkg::CFG_INDEX_W-1:0] idx, input logic val);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == wkfc_pkg::CFG_SHAPER_MODE)
            shaper_mode_q = val;
        else
            range_mode_q = val;
    endtask

    task automatic set_modes(input logic shp, input logic rng);
        write_reg(wkfc_pkg::CFG_SHAPER_MODE, shp);
        write_reg(wkfc_pkg::CFG_RANGE_MODE, rng);
    endtask

    function automatic logic signed [14:0] rand_sample;
        case ($urandom_range(0, 9))
            0: return 15'($urandom);
            1: return ($urandom_range(0, 1) == 1) ? 15'sh3fff : 15'sh4000;
            2: return (range_mode_q == wkfc_pkg::RANGE_UNIPOLAR) ? 15'sd5000 : 15'sd0;
            default: return 15'($signed($urandom_range(0, 16000)) - 5500);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_mod;
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1: return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
            2: return 16'($signed($urandom_range(0, 128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // reset state: knee crossfade, bipolar range
    task automatic test_reset_state;
        gap_max = 2;
        stall_pct = 20;
        stall_len = 2;
        send_request(0, 0);
        send_request(0, 12345);
        send_request(3000, 0);
        send_request(5000, 0);
        send_request(-5000, 0);
        send_request(15'sh3fff, 16'sh7fff);
        send_request(15'sh4000, 16'sh8000);
        send_request(12000, -32767);
        send_request(-12000, 32767);
        send_request(700, 32767);
        send_request(4000, 20000);
        send_request(-700, -20000);
        send_request(4500, 16'sh8000);
        send_request(1, 1);
    endtask

    task automatic test_clamp_fold;
        set_modes(wkfc_pkg::SHAPE_CLAMP_FOLD, wkfc_pkg::RANGE_BIPOLAR);
        send_request(2000, 16'sh8000);
        send_request(-2000, -16384);
        send_request(4000, 32767);
        send_request(1000, 16384);
        send_request(-3000, 32767);
        send_request(5000, 1);
    endtask

    task automatic test_unipolar;
        set_modes(wkfc_pkg::SHAPE_KNEE, wkfc_pkg::RANGE_UNIPOLAR);
        send_request(0, 20000);
        send_request(10000, -20000);
        send_request(5000, 32767);
        set_modes(wkfc_pkg::SHAPE_CLAMP_FOLD, wkfc_pkg::RANGE_UNIPOLAR);
        send_request(-100, 32767);
        send_request(15'sh3fff, 16'sh8000);
        send_request(7500, 30000);
    endtask

    task automatic test_random_modes;
        int k;
        int i;
        for (k = 0; k < 4; k++)
        begin
            set_modes(k[0] ? wkfc_pkg::SHAPE_CLAMP_FOLD : wkfc_pkg::SHAPE_KNEE,
                      k[1] ? wkfc_pkg::RANGE_UNIPOLAR : wkfc_pkg::RANGE_BIPOLAR);
            // first setting runs with no idling on either side
            gap_max = 3 * k;
            stall_pct = (k == 0) ? 0 : 15 * k;
            stall_len = (k == 0) ? 0 : k + 1;
            for (i = 0; i < 185; i++)
                send_request(rand_sample(), rand_mod());
        end
    endtask

    // long output hold-off while requests keep coming
    task automatic test_backpressure;
        int i;
        set_modes(wkfc_pkg::SHAPE_KNEE, wkfc_pkg::RANGE_BIPOLAR);
        gap_max = 0;
        stall_pct = 0;
        stall_len = 0;
        @(posedge clk);
        hold_off_req = 300;
        for (i = 0; i < 60; i++)
            send_request(rand_sample(), rand_mod());
    endtask

    always @(negedge clk)
    begin
        rx_phase++;
        if (hold_off_req > 0)
        begin
            hold_cnt = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = !((rx_phase % 11) < stall_len) &&
                            ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_shaped
        shaped_t want;
        logic signed [14:0] got_mv;
        logic signed [15:0] got_norm;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_mv = m_axis_tdata[14:0];
            got_norm = m_axis_tdata[30:15];
            if (shaped_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result mv %0d norm %0d", $time, got_mv, got_norm);
            end
            else
            begin
                want = shaped_q.pop_front();
                results_checked++;
                if (got_mv !== want.mv)
                begin
                    errors++;
                    $display("%0t: shaped_mv expected %0d actual %0d",
                             $time, want.mv, got_mv);
                end
                if (got_norm !== want.norm)
                begin
                    errors++;
                    $display("%0t: shaped_norm expected %0d actual %0d",
                             $time, want.norm, got_norm);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_state();
        test_clamp_fold();
        test_unipolar();
        test_random_modes();
        test_backpressure();
        drain();
        $display("tb: %0d requests, %0d results checked in all four mode settings",
                 requests_sent, results_checked);
        $display("tb: output hold-off of 300 cycles exercised, %0d mismatches", errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/wkfc_pkg.sv
rtl/wkfc_norm.sv
rtl/wkfc_shape.sv
rtl/wkfc_outmap.sv
rtl/waveshaper_knee_fold_clamp.sv
test/tb.sv
